/* hdl/tbcp_pkg.sv */
// Shared types, constants and decode functions for the tube Bezier control point generator.
`timescale 1ns / 1ps

package tbcp_pkg;

	// Coordinate format: signed fixed point, fraction width does not affect the math.
	localparam int COORD_WIDTH = 24;

	// Width of |3*d| + 5, where d is the difference of two coordinates.
	localparam int MAG_WIDTH = COORD_WIDTH + 2;

	// Reciprocal of ten, scaled so that the truncated product is an exact floor(n/10).
	localparam int RECIP_SHIFT = MAG_WIDTH + 4;
	localparam int RECIP_WIDTH = COORD_WIDTH + 3;
	localparam logic [RECIP_WIDTH-1:0] RECIP_TENTH =
		RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);
	localparam int PROD_WIDTH = MAG_WIDTH + RECIP_WIDTH;

	// Quotient of the scaled difference, and the width of base plus offset.
	localparam int QUOT_WIDTH = COORD_WIDTH - 1;
	localparam int SUM_WIDTH = COORD_WIDTH + 2;

	// Rounding bias for round-half-away-from-zero of n/10.
	localparam logic [MAG_WIDTH-1:0] ROUND_BIAS = MAG_WIDTH'(5);

	// Six arithmetic lanes: x, y, z of the second point, then of the third point.
	localparam int AXES = 3;
	localparam int LANES = 2 * AXES;

	// Job queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
	localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

	// Window fill count saturates at three residues.
	localparam logic [1:0] FILL_EMPTY = 2'd0;
	localparam logic [1:0] FILL_FULL = 2'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [AXES-1:0][COORD_WIDTH-1:0] vec3_t;
	typedef logic [1:0] class_t;
	typedef logic [3:0] rad_t;
	typedef logic [7:0] color_t;
	typedef logic [1:0] beat_t;

	localparam int BEATS = 4;
	localparam beat_t BEAT_LAST = beat_t'(BEATS - 1);

	// Structure class codes; the unused code behaves as coil.
	localparam class_t CLS_COIL = 2'd0;
	localparam class_t CLS_HELIX = 2'd1;
	localparam class_t CLS_SHEET = 2'd2;

	// Tube radii in tenths of an angstrom.
	localparam rad_t RAD_THIN = 4'd3;
	localparam rad_t RAD_NARROW = 4'd6;
	localparam rad_t RAD_WIDE = 4'd9;
	localparam rad_t RAD_ARROW = 4'd12;

	localparam color_t COLOR_FULL = 8'd255;
	localparam color_t COLOR_GRAY = 8'd200;
	localparam color_t COLOR_NONE = 8'd0;

	// Attributes kept for each residue in the window.
	typedef struct packed {
		class_t cls;
		logic at_end;
		logic next_helix;
		logic amino;
	} res_attr_t;

	// Attributes of the middle residue that set radius and color of a curve.
	typedef struct packed {
		class_t cls;
		logic at_end;
		logic next_helix;
	} curve_attr_t;

	// One curve to compute: four window positions and the middle residue's attributes.
	typedef struct packed {
		vec3_t p0;
		vec3_t p1;
		vec3_t p2;
		vec3_t p3;
		curve_attr_t attr;
	} job_t;

	typedef struct packed {
		color_t red;
		color_t green;
		color_t blue;
	} rgb_t;

	// Tube radius of one control point, with arrow heads at sheet ends.
	function automatic rad_t radius_of(curve_attr_t attr, beat_t idx);
		rad_t rad;
		case (attr.cls)
			CLS_SHEET: begin
				if (attr.at_end) begin
					case (idx)
						2'd0: rad = RAD_ARROW;
						2'd1: rad = RAD_WIDE;
						2'd2: rad = RAD_NARROW;
						default: rad = RAD_THIN;
					endcase
				end else begin
					rad = RAD_WIDE;
				end
			end
			CLS_HELIX: begin
				rad = (idx == BEAT_LAST && attr.at_end) ? RAD_THIN : RAD_WIDE;
			end
			default: begin
				rad = (idx == BEAT_LAST && attr.at_end && attr.next_helix) ?
					RAD_WIDE : RAD_THIN;
			end
		endcase
		return rad;
	endfunction

	// Class color: helix red, sheet blue, coil gray.
	function automatic rgb_t color_of(class_t cls);
		rgb_t rgb;
		case (cls)
			CLS_SHEET: rgb = '{red: COLOR_NONE, green: COLOR_NONE, blue: COLOR_FULL};
			CLS_HELIX: rgb = '{red: COLOR_FULL, green: COLOR_NONE, blue: COLOR_NONE};
			default: rgb = '{red: COLOR_GRAY, green: COLOR_GRAY, blue: COLOR_GRAY};
		endcase
		return rgb;
	endfunction

endpackage

/* hdl/tbcp_front.sv */
// Front end: residue window, chain tracking and curve classification.
`timescale 1ns / 1ps

module tbcp_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tbcp_pkg::coord_t       ca_x,
	input  tbcp_pkg::coord_t       ca_y,
	input  tbcp_pkg::coord_t       ca_z,
	input  tbcp_pkg::class_t       structure_class,
	input  logic                   structure_end,
	input  logic                   next_is_helix,
	input  logic                   is_amino,
	input  logic                   chain_first,
	input  logic                   chain_last,
	input  logic                   residue_valid,
	output logic                   residue_ready,
	output logic                   job_valid,
	input  logic                   job_ready,
	output tbcp_pkg::job_t         job
);
	import tbcp_pkg::*;

	// Window of the three previous residues; entry 0 is the oldest.
	vec3_t     win_pos_q [AXES];
	res_attr_t win_attr_q [AXES];
	logic [1:0] fill_q;

	logic       accept;
	logic [1:0] fill_eff;
	logic       emit;

	// A residue is taken whenever the queue could hold a job for it.
	assign residue_ready = job_ready;
	assign accept = residue_valid && residue_ready;

	// A chain start empties the window before the residue is considered.
	assign fill_eff = chain_first ? FILL_EMPTY : fill_q;

	// A curve needs a full window, no chain end, and four amino residues.
	assign emit = (fill_eff == FILL_FULL) && !chain_last && is_amino &&
		win_attr_q[0].amino && win_attr_q[1].amino && win_attr_q[2].amino;

	assign job_valid = residue_valid && emit;

	always_comb begin
		job.p0 = win_pos_q[0];
		job.p1 = win_pos_q[1];
		job.p2 = win_pos_q[2];
		job.p3 = {ca_z, ca_y, ca_x};
		job.attr.cls = win_attr_q[1].cls;
		job.attr.at_end = win_attr_q[1].at_end;
		job.attr.next_helix = win_attr_q[1].next_helix;
	end

	// Fill count: saturates at three and is cleared after a chain end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_EMPTY;
		end else if (accept) begin
			if (chain_last) begin
				fill_q <= FILL_EMPTY;
			end else if (fill_eff == FILL_FULL) begin
				fill_q <= FILL_FULL;
			end else begin
				fill_q <= fill_eff + 2'd1;
			end
		end
	end

	// Every accepted residue shifts into the window.
	always_ff @(posedge clk) begin
		if (accept) begin
			win_pos_q[0] <= win_pos_q[1];
			win_pos_q[1] <= win_pos_q[2];
			win_pos_q[2] <= {ca_z, ca_y, ca_x};
			win_attr_q[0] <= win_attr_q[1];
			win_attr_q[1] <= win_attr_q[2];
			win_attr_q[2] <= '{cls: structure_class, at_end: structure_end,
				next_helix: next_is_helix, amino: is_amino};
		end
	end

endmodule

/* hdl/tbcp_queue.sv */
// Short job queue that decouples the front end from the arithmetic back end.
`timescale 1ns / 1ps

module tbcp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  tbcp_pkg::job_t  push_job,
	output logic            pop_valid,
	input  logic            pop_ready,
	output tbcp_pkg::job_t  pop_job
);
	import tbcp_pkg::*;

	job_t                  mem_q [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0] wr_ptr_q;
	logic [QPTR_WIDTH-1:0] rd_ptr_q;
	logic [QCNT_WIDTH-1:0] cnt_q;

	logic push;
	logic pop;

	assign push_ready = (cnt_q != QCNT_WIDTH'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_job = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* hdl/tbcp_back.sv */
// Back end: scaled differences, division by ten, saturation and the point sequencer.
`timescale 1ns / 1ps

module tbcp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  tbcp_pkg::job_t   job,
	output logic             point_valid,
	input  logic             point_ready,
	output tbcp_pkg::coord_t point_x,
	output tbcp_pkg::coord_t point_y,
	output tbcp_pkg::coord_t point_z,
	output tbcp_pkg::rad_t   radius_tenths,
	output tbcp_pkg::color_t red,
	output tbcp_pkg::color_t green,
	output tbcp_pkg::color_t blue,
	output tbcp_pkg::beat_t  point_index,
	output logic             last_point
);
	import tbcp_pkg::*;

	// Lane operands and the rounded magnitude of 3*(a-b) plus the bias.
	logic [COORD_WIDTH-1:0] lane_a [LANES];
	logic [COORD_WIDTH-1:0] lane_b [LANES];
	logic [COORD_WIDTH:0]   lane_diff [LANES];
	logic [COORD_WIDTH+2:0] lane_tri [LANES];
	logic [COORD_WIDTH+2:0] lane_abs [LANES];
	logic [MAG_WIDTH-1:0]   lane_mag [LANES];

	// Stage 1: magnitudes and signs.
	logic                 valid_s1;
	logic [MAG_WIDTH-1:0] mag_s1 [LANES];
	logic [LANES-1:0]     neg_s1;
	vec3_t                p1_s1;
	vec3_t                p2_s1;
	curve_attr_t          attr_s1;

	// Stage 2: products with the reciprocal of ten.
	logic                  valid_s2;
	logic [PROD_WIDTH-1:0] prod_s2 [LANES];
	logic [LANES-1:0]      neg_s2;
	vec3_t                 p1_s2;
	vec3_t                 p2_s2;
	curve_attr_t           attr_s2;

	// Quotient, signed offset, base plus offset and the saturated point.
	logic [QUOT_WIDTH-1:0]  lane_quot [LANES];
	logic [COORD_WIDTH:0]   lane_off [LANES];
	logic [COORD_WIDTH-1:0] lane_base [LANES];
	logic [SUM_WIDTH-1:0]   lane_sum [LANES];
	logic [COORD_WIDTH-1:0] lane_sat [LANES];

	// Output bank: four points of one curve, sent one per beat.
	logic        bank_valid_q;
	vec3_t       pt_q [BEATS];
	curve_attr_t attr_q;
	beat_t       beat_q;

	logic ready_s1;
	logic ready_s2;
	logic bank_ready;
	logic out_beat;
	rgb_t rgb;

	// Handshake chain through the stages.
	assign out_beat = point_valid && point_ready;
	assign bank_ready = !bank_valid_q || (point_ready && beat_q == BEAT_LAST);
	assign ready_s2 = !valid_s2 || bank_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign job_ready = ready_s1;

	// Operand selection: lanes 0..2 scale p2-p0, lanes 3..5 scale p1-p3.
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			lane_a[i] = job.p2[i];
			lane_b[i] = job.p0[i];
			lane_a[i+AXES] = job.p1[i];
			lane_b[i+AXES] = job.p3[i];
		end
	end

	// Triple the difference, take its magnitude and add the rounding bias.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lane_diff[l] = {lane_a[l][COORD_WIDTH-1], lane_a[l]} -
				{lane_b[l][COORD_WIDTH-1], lane_b[l]};
			lane_tri[l] = {{2{lane_diff[l][COORD_WIDTH]}}, lane_diff[l]} +
				{lane_diff[l][COORD_WIDTH], lane_diff[l], 1'b0};
			lane_abs[l] = lane_tri[l][COORD_WIDTH+2] ? -lane_tri[l] : lane_tri[l];
			lane_mag[l] = lane_abs[l][MAG_WIDTH-1:0] + ROUND_BIAS;
		end
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			bank_valid_q <= 1'b0;
			beat_q <= '0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= job_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (bank_ready) begin
				bank_valid_q <= valid_s2;
			end
			if (bank_ready && valid_s2) begin
				beat_q <= '0;
			end else if (out_beat) begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (ready_s1 && job_valid) begin
			for (int l = 0; l < LANES; l++) begin
				mag_s1[l] <= lane_mag[l];
				neg_s1[l] <= lane_tri[l][COORD_WIDTH+2];
			end
			p1_s1 <= job.p1;
			p2_s1 <= job.p2;
			attr_s1 <= job.attr;
		end
	end

	// Stage 2 payload: one multiplier per lane.
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			for (int l = 0; l < LANES; l++) begin
				prod_s2[l] <= PROD_WIDTH'(mag_s1[l]) * PROD_WIDTH'(RECIP_TENTH);
			end
			neg_s2 <= neg_s1;
			p1_s2 <= p1_s1;
			p2_s2 <= p2_s1;
			attr_s2 <= attr_s1;
		end
	end

	// Restore the sign, add the base point and saturate to the coordinate range.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lane_base[l] = (l < AXES) ? p1_s2[l % AXES] : p2_s2[l % AXES];
			lane_quot[l] = prod_s2[l][RECIP_SHIFT +: QUOT_WIDTH];
			lane_off[l] = neg_s2[l] ? -{2'b00, lane_quot[l]} : {2'b00, lane_quot[l]};
			lane_sum[l] = {{2{lane_base[l][COORD_WIDTH-1]}}, lane_base[l]} +
				{lane_off[l][COORD_WIDTH], lane_off[l]};
			if (lane_sum[l][SUM_WIDTH-1:COORD_WIDTH-1] == '0 ||
				lane_sum[l][SUM_WIDTH-1:COORD_WIDTH-1] == '1) begin
				lane_sat[l] = lane_sum[l][COORD_WIDTH-1:0];
			end else if (lane_sum[l][SUM_WIDTH-1]) begin
				lane_sat[l] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
			end else begin
				lane_sat[l] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end
		end
	end

	// Output bank load.
	always_ff @(posedge clk) begin
		if (bank_ready && valid_s2) begin
			pt_q[0] <= p1_s2;
			pt_q[3] <= p2_s2;
			for (int i = 0; i < AXES; i++) begin
				pt_q[1][i] <= lane_sat[i];
				pt_q[2][i] <= lane_sat[i+AXES];
			end
			attr_q <= attr_s2;
		end
	end

	// Beat fields come from the bank, selected by the beat counter.
	assign rgb = color_of(attr_q.cls);
	assign point_valid = bank_valid_q;
	assign point_x = pt_q[beat_q][0];
	assign point_y = pt_q[beat_q][1];
	assign point_z = pt_q[beat_q][2];
	assign radius_tenths = radius_of(attr_q, beat_q);
	assign red = rgb.red;
	assign green = rgb.green;
	assign blue = rgb.blue;
	assign point_index = beat_q;
	assign last_point = (beat_q == BEAT_LAST);

endmodule

/* hdl/tube_bezier_control_point_generator_top.sv */
// Top level of the tube Bezier control point generator.
// A residue that completes a curve passes through the job queue, stage 1, stage 2 and the
// output bank before its first point appears; the other three points follow in order.
// Points of a curve leave one at a time through the single result port; residues
// that give no curve are taken at one per cycle while the two-entry job queue has room.
// Reset clears the window fill count, the queue and the pipeline valid bits at once.
`timescale 1ns / 1ps

module tube_bezier_control_point_generator_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             residue_valid,
	output logic             residue_ready,
	input  tbcp_pkg::coord_t ca_x,
	input  tbcp_pkg::coord_t ca_y,
	input  tbcp_pkg::coord_t ca_z,
	input  tbcp_pkg::class_t structure_class,
	input  logic             structure_end,
	input  logic             next_is_helix,
	input  logic             is_amino,
	input  logic             chain_first,
	input  logic             chain_last,
	output logic             point_valid,
	input  logic             point_ready,
	output tbcp_pkg::coord_t point_x,
	output tbcp_pkg::coord_t point_y,
	output tbcp_pkg::coord_t point_z,
	output tbcp_pkg::rad_t   radius_tenths,
	output tbcp_pkg::color_t red,
	output tbcp_pkg::color_t green,
	output tbcp_pkg::color_t blue,
	output tbcp_pkg::beat_t  point_index,
	output logic             last_point
);
	import tbcp_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	// Window and classification.
	tbcp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.ca_x            (ca_x),
		.ca_y            (ca_y),
		.ca_z            (ca_z),
		.structure_class (structure_class),
		.structure_end   (structure_end),
		.next_is_helix   (next_is_helix),
		.is_amino        (is_amino),
		.chain_first     (chain_first),
		.chain_last      (chain_last),
		.residue_valid   (residue_valid),
		.residue_ready   (residue_ready),
		.job_valid       (push_valid),
		.job_ready       (push_ready),
		.job             (push_job)
	);

	// Jobs waiting for the arithmetic.
	tbcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// Control point arithmetic and the result sequencer.
	tbcp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (pop_valid),
		.job_ready     (pop_ready),
		.job           (pop_job),
		.point_valid   (point_valid),
		.point_ready   (point_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.radius_tenths (radius_tenths),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.point_index   (point_index),
		.last_point    (last_point)
	);

endmodule

/* hdl/tbcp_checker.sv */
// Port-level checks on the result channel of the control point generator, with its bind.
`timescale 1ns / 1ps

module tbcp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             point_valid,
	input logic             point_ready,
	input tbcp_pkg::coord_t point_x,
	input tbcp_pkg::rad_t   radius_tenths,
	input tbcp_pkg::color_t red,
	input tbcp_pkg::color_t green,
	input tbcp_pkg::color_t blue,
	input tbcp_pkg::beat_t  point_index,
	input logic             last_point
);
	import tbcp_pkg::*;

	// A stalled beat stays up with its x coordinate and point index held.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=>
			point_valid && $stable(point_x) && $stable(point_index))
		else $error("result beat dropped or changed while stalled");

	// Within a curve the next beat follows at once with the next point index.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready && !last_point |=>
			point_valid && point_index == $past(point_index) + 2'd1)
		else $error("control point sequence broken inside a curve");

	// All four points of a curve carry one color.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready && !last_point |=>
			red == $past(red) && green == $past(green) && blue == $past(blue))
		else $error("color changed inside a curve");

	// Only the four tube radii appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> radius_tenths == RAD_THIN || radius_tenths == RAD_NARROW ||
			radius_tenths == RAD_WIDE || radius_tenths == RAD_ARROW)
		else $error("illegal tube radius");

	// The last-point flag marks exactly the fourth point.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> last_point == (point_index == BEAT_LAST))
		else $error("last point flag does not match point index");

endmodule

bind tube_bezier_control_point_generator_top tbcp_checker u_tbcp_checker (.*);

/* dv/tbcp_point_checker.sv */
// Checker that predicts the control point stream from accepted residues and compares it.
`timescale 1ns / 1ps

module tbcp_point_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             residue_valid,
	input  logic             residue_ready,
	input  tbcp_pkg::coord_t ca_x,
	input  tbcp_pkg::coord_t ca_y,
	input  tbcp_pkg::coord_t ca_z,
	input  tbcp_pkg::class_t structure_class,
	input  logic             structure_end,
	input  logic             next_is_helix,
	input  logic             is_amino,
	input  logic             chain_first,
	input  logic             chain_last,
	input  logic             point_valid,
	input  logic             point_ready,
	input  tbcp_pkg::coord_t point_x,
	input  tbcp_pkg::coord_t point_y,
	input  tbcp_pkg::coord_t point_z,
	input  tbcp_pkg::rad_t   radius_tenths,
	input  tbcp_pkg::color_t red,
	input  tbcp_pkg::color_t green,
	input  tbcp_pkg::color_t blue,
	input  tbcp_pkg::beat_t  point_index,
	input  logic             last_point,
	output int               mismatch_count,
	output int               points_pending,
	output int               points_checked
);
	import tbcp_pkg::*;

	// One predicted control point beat.
	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		rad_t   radius;
		color_t red;
		color_t green;
		color_t blue;
		beat_t  index;
		logic   last;
	} ctrl_point_t;

	ctrl_point_t expected_points[$];

	// Residue window: entry 0 is the oldest, entry 2 the most recent.
	coord_t    win_x[3];
	coord_t    win_y[3];
	coord_t    win_z[3];
	res_attr_t win_attr[3];
	int        win_fill;

	int errors_seen;
	int beats_seen;

	// Base plus 3/10 of (toward - away), rounded half away from zero, then saturated.
	function automatic coord_t tangent_point(coord_t base, coord_t toward, coord_t away);
		longint diff3;
		longint q;
		longint lim_hi;
		longint lim_lo;
		diff3 = 3 * (longint'(toward) - longint'(away));
		if (diff3 < 0) begin
			q = -((-diff3 + 5) / 10);
		end else begin
			q = (diff3 + 5) / 10;
		end
		q = q + longint'(base);
		lim_hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		lim_lo = -lim_hi - 1;
		if (q > lim_hi) begin
			q = lim_hi;
		end
		if (q < lim_lo) begin
			q = lim_lo;
		end
		return coord_t'(q);
	endfunction

	// Works out the curve, if any, for one accepted residue and shifts it into the window.
	task automatic predict_curve(coord_t nx, coord_t ny, coord_t nz, res_attr_t new_attr,
			logic starts_chain, logic ends_chain);
		res_attr_t   mid;
		coord_t      px[4];
		coord_t      py[4];
		coord_t      pz[4];
		ctrl_point_t pt;
		color_t      cr;
		color_t      cg;
		color_t      cb;
		rad_t        rad;
		if (starts_chain) begin
			win_fill = 0;
		end
		if (win_fill >= 3 && !ends_chain && new_attr.amino &&
				win_attr[0].amino && win_attr[1].amino && win_attr[2].amino) begin
			mid = win_attr[1];
			case (mid.cls)
				CLS_SHEET: begin
					cr = COLOR_NONE;
					cg = COLOR_NONE;
					cb = COLOR_FULL;
				end
				CLS_HELIX: begin
					cr = COLOR_FULL;
					cg = COLOR_NONE;
					cb = COLOR_NONE;
				end
				default: begin
					cr = COLOR_GRAY;
					cg = COLOR_GRAY;
					cb = COLOR_GRAY;
				end
			endcase
			px[0] = win_x[1];
			py[0] = win_y[1];
			pz[0] = win_z[1];
			px[1] = tangent_point(win_x[1], win_x[2], win_x[0]);
			py[1] = tangent_point(win_y[1], win_y[2], win_y[0]);
			pz[1] = tangent_point(win_z[1], win_z[2], win_z[0]);
			px[2] = tangent_point(win_x[2], win_x[1], nx);
			py[2] = tangent_point(win_y[2], win_y[1], ny);
			pz[2] = tangent_point(win_z[2], win_z[1], nz);
			px[3] = win_x[2];
			py[3] = win_y[2];
			pz[3] = win_z[2];
			for (int k = 0; k < 4; k++) begin
				// Sheet ends taper as an arrow; helix and coil only change the final beat.
				if (mid.cls == CLS_SHEET) begin
					if (!mid.at_end) begin
						rad = RAD_WIDE;
					end else if (k == 0) begin
						rad = RAD_ARROW;
					end else if (k == 1) begin
						rad = RAD_WIDE;
					end else if (k == 2) begin
						rad = RAD_NARROW;
					end else begin
						rad = RAD_THIN;
					end
				end else if (mid.cls == CLS_HELIX) begin
					rad = (k == 3 && mid.at_end) ? RAD_THIN : RAD_WIDE;
				end else begin
					rad = (k == 3 && mid.at_end && mid.next_helix) ? RAD_WIDE : RAD_THIN;
				end
				pt.x = px[k];
				pt.y = py[k];
				pt.z = pz[k];
				pt.radius = rad;
				pt.red = cr;
				pt.green = cg;
				pt.blue = cb;
				pt.index = beat_t'(k);
				pt.last = (k == 3);
				expected_points.push_back(pt);
			end
		end
		win_x[0] = win_x[1];
		win_x[1] = win_x[2];
		win_x[2] = nx;
		win_y[0] = win_y[1];
		win_y[1] = win_y[2];
		win_y[2] = ny;
		win_z[0] = win_z[1];
		win_z[1] = win_z[2];
		win_z[2] = nz;
		win_attr[0] = win_attr[1];
		win_attr[1] = win_attr[2];
		win_attr[2] = new_attr;
		if (win_fill < 3) begin
			win_fill++;
		end
		if (ends_chain) begin
			win_fill = 0;
		end
	endtask

	task automatic compare_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors_seen++;
		end
	endtask

	// Compare each output beat with the oldest prediction, then predict for the input beat.
	always @(posedge clk or negedge arst_n) begin
		ctrl_point_t want;
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_x[i] = '0;
				win_y[i] = '0;
				win_z[i] = '0;
				win_attr[i] = '0;
			end
			win_fill = 0;
			expected_points.delete();
			errors_seen = 0;
			beats_seen = 0;
		end else begin
			if (point_valid && point_ready) begin
				beats_seen++;
				if (expected_points.size() == 0) begin
					$error("control point beat arrived with no prediction waiting");
					errors_seen++;
				end else begin
					want = expected_points.pop_front();
					compare_field("point_x", longint'(want.x), longint'(point_x));
					compare_field("point_y", longint'(want.y), longint'(point_y));
					compare_field("point_z", longint'(want.z), longint'(point_z));
					compare_field("radius_tenths", longint'(want.radius),
						longint'(radius_tenths));
					compare_field("red", longint'(want.red), longint'(red));
					compare_field("green", longint'(want.green), longint'(green));
					compare_field("blue", longint'(want.blue), longint'(blue));
					compare_field("point_index", longint'(want.index),
						longint'(point_index));
					compare_field("last_point", longint'(want.last), longint'(last_point));
				end
			end
			if (residue_valid && residue_ready) begin
				predict_curve(ca_x, ca_y, ca_z,
					'{cls: structure_class, at_end: structure_end,
					  next_helix: next_is_helix, amino: is_amino},
					chain_first, chain_last);
			end
		end
		mismatch_count <= errors_seen;
		points_pending <= expected_points.size();
		points_checked <= beats_seen;
	end

endmodule

/* dv/tb_tube_bezier_control_point_generator_top.sv */
// Testbench top: residue stimulus, handshake pacing and the final verdict.
`timescale 1ns / 1ps

module tb_tube_bezier_control_point_generator_top;
	import tbcp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_RESIDUES = 62;
	localparam int SETTLE_CYCLES = 16;
	localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	// One residue as driven on the input channel.
	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		class_t cls;
		logic   send;
		logic   nhel;
		logic   amino;
		logic   first;
		logic   last;
	} residue_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   residue_valid = 1'b0;
	logic   residue_ready;
	coord_t ca_x = '0;
	coord_t ca_y = '0;
	coord_t ca_z = '0;
	class_t structure_class = CLS_COIL;
	logic   structure_end = 1'b0;
	logic   next_is_helix = 1'b0;
	logic   is_amino = 1'b0;
	logic   chain_first = 1'b0;
	logic   chain_last = 1'b0;
	logic   point_valid;
	logic   point_ready = 1'b0;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	rad_t   radius_tenths;
	color_t red;
	color_t green;
	color_t blue;
	beat_t  point_index;
	logic   last_point;

	int mismatch_count;
	int points_pending;
	int points_checked;

	int idle_pct = 0;
	int stall_pct = 0;
	int residues_sent = 0;
	int cycle_count = 0;
	residue_t residue_fifo[$];

	tube_bezier_control_point_generator_top DUT (.*);

	tbcp_point_checker checker_i (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		point_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tube_bezier_control_point_generator_top verification failed");
			$finish;
		end
	end

	function automatic residue_t residue(longint x, longint y, longint z, class_t cls,
			logic send, logic nhel, logic amino, logic first, logic last);
		residue_t r;
		r.x = coord_t'(x);
		r.y = coord_t'(y);
		r.z = coord_t'(z);
		r.cls = cls;
		r.send = send;
		r.nhel = nhel;
		r.amino = amino;
		r.first = first;
		r.last = last;
		return r;
	endfunction

	// Drives one input beat, with random idle cycles before it, and waits for acceptance.
	task automatic send_residue(residue_t r);
		while ($urandom_range(99) < idle_pct) begin
			residue_valid <= 1'b0;
			@(posedge clk);
		end
		residue_valid <= 1'b1;
		ca_x <= r.x;
		ca_y <= r.y;
		ca_z <= r.z;
		structure_class <= r.cls;
		structure_end <= r.send;
		next_is_helix <= r.nhel;
		is_amino <= r.amino;
		chain_first <= r.first;
		chain_last <= r.last;
		do begin
			@(posedge clk);
		end while (!residue_ready);
		residues_sent++;
	endtask

	task automatic send_fifo();
		while (residue_fifo.size() != 0) begin
			send_residue(residue_fifo.pop_front());
		end
	endtask

	// Holds the sender off until every predicted point has arrived and the pipe is empty.
	task automatic drain();
		residue_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (points_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic class_t random_class();
		int pick;
		pick = $urandom_range(19);
		return (pick == 0) ? class_t'(3) : class_t'(pick % 3);
	endfunction

	function automatic coord_t walk(coord_t prev);
		if ($urandom_range(11) == 0) begin
			return coord_t'($urandom);
		end
		return coord_t'(longint'(prev) + int'($urandom_range(2400)) - 1200);
	endfunction

	// Queues a chain of residues: a random walk with runs of structure classes.
	task automatic queue_chain();
		class_t   cls_seq[16];
		class_t   next_cls;
		int       len;
		coord_t   px;
		coord_t   py;
		coord_t   pz;
		residue_t r;
		len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
		for (int k = 0; k < len; k++) begin
			cls_seq[k] = (k == 0 || $urandom_range(2) == 0) ? random_class() : cls_seq[k - 1];
		end
		if ($urandom_range(7) == 0) begin
			px = coord_t'($urandom);
			py = coord_t'($urandom);
			pz = coord_t'($urandom);
		end else begin
			px = coord_t'(int'($urandom_range(131072)) - 65536);
			py = coord_t'(int'($urandom_range(131072)) - 65536);
			pz = coord_t'(int'($urandom_range(131072)) - 65536);
		end
		for (int k = 0; k < len; k++) begin
			next_cls = (k + 1 < len) ? cls_seq[k + 1] : random_class();
			px = walk(px);
			py = walk(py);
			pz = walk(pz);
			r = residue(longint'(px), longint'(py), longint'(pz), cls_seq[k],
				((k + 1 == len) || next_cls != cls_seq[k]) ^ ($urandom_range(7) == 0),
				(next_cls == CLS_HELIX) ^ ($urandom_range(7) == 0),
				$urandom_range(31) != 0,
				k == 0 && $urandom_range(7) != 0,
				k == len - 1 && $urandom_range(7) != 0);
			residue_fifo.push_back(r);
		end
	endtask

	// Queues a few residues with every field random.
	task automatic queue_noise();
		int n;
		n = $urandom_range(1, 3);
		repeat (n) begin
			residue_fifo.push_back(residue(longint'(coord_t'($urandom)),
				longint'(coord_t'($urandom)), longint'(coord_t'($urandom)),
				class_t'($urandom_range(3)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1))));
		end
	endtask

	initial begin
		int phase_start;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the window fills straight after reset without a chain start mark,
		// saturation both ways, every class and radius rule, and rounding ties.
		residue_fifo.push_back(residue(COORD_MIN, COORD_MAX, 0, CLS_COIL, 0, 0, 1, 0, 0));
		residue_fifo.push_back(residue(COORD_MAX, COORD_MIN, 1, CLS_SHEET, 1, 0, 1, 0, 0));
		residue_fifo.push_back(residue(COORD_MAX, COORD_MIN, -1, CLS_HELIX, 1, 0, 1, 0, 0));
		residue_fifo.push_back(residue(COORD_MIN, COORD_MAX, 5, CLS_COIL, 1, 1, 1, 0, 0));
		residue_fifo.push_back(residue(0, 0, 0, class_t'(3), 1, 1, 1, 0, 0));
		residue_fifo.push_back(residue(-5, 5, 3, CLS_SHEET, 0, 0, 1, 0, 0));
		residue_fifo.push_back(residue(1, -1, 2, CLS_HELIX, 0, 1, 1, 0, 0));
		residue_fifo.push_back(residue(-4, 6, -15, CLS_COIL, 1, 0, 1, 0, 0));
		// A non-amino residue suppresses every curve whose window holds it.
		residue_fifo.push_back(residue(100, 200, 300, CLS_COIL, 0, 0, 0, 0, 0));
		residue_fifo.push_back(residue(110, 210, 310, CLS_HELIX, 0, 0, 1, 0, 0));
		residue_fifo.push_back(residue(120, 220, 320, CLS_HELIX, 0, 0, 1, 0, 0));
		residue_fifo.push_back(residue(130, 230, 330, CLS_SHEET, 1, 0, 1, 0, 0));
		residue_fifo.push_back(residue(140, 240, 340, CLS_SHEET, 0, 0, 1, 0, 1));
		// After a chain end the next residue starts afresh even without a start mark.
		residue_fifo.push_back(residue(-1000, 0, 1000, CLS_SHEET, 0, 0, 1, 0, 0));
		residue_fifo.push_back(residue(-700, 300, 1300, CLS_SHEET, 1, 1, 1, 0, 0));
		residue_fifo.push_back(residue(-400, 600, 1600, CLS_COIL, 0, 1, 1, 0, 0));
		residue_fifo.push_back(residue(-100, 900, 1900, CLS_COIL, 1, 0, 1, 0, 0));
		// A chain start mark in the middle of a chain clears the window.
		residue_fifo.push_back(residue(COORD_MAX, COORD_MAX, COORD_MIN, CLS_HELIX, 0, 0, 1, 1, 0));
		residue_fifo.push_back(residue(COORD_MIN, COORD_MIN, COORD_MAX, CLS_HELIX, 1, 0, 1, 0, 0));
		residue_fifo.push_back(residue(COORD_MIN, COORD_MIN, COORD_MAX, CLS_COIL, 0, 1, 1, 0, 0));
		residue_fifo.push_back(residue(COORD_MAX, COORD_MAX, COORD_MIN, CLS_COIL, 0, 0, 1, 0, 0));
		residue_fifo.push_back(residue(7, 7, 7, CLS_COIL, 0, 0, 1, 0, 0));
		send_fifo();
		drain();

		// Random chains and noise under four pacing phases, drained between phases.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 83;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 83;
				end
				default: begin
					idle_pct = 19;
					stall_pct = 19;
				end
			endcase
			phase_start = residues_sent;
			while (residues_sent - phase_start < PHASE_RESIDUES) begin
				if ($urandom_range(6) == 0) begin
					queue_noise();
				end else begin
					queue_chain();
				end
				send_fifo();
			end
			drain();
		end

		$display("Run covered %0d residues over four pacing phases after a directed chain;",
			residues_sent);
		$display("%0d control point beats were compared field by field.", points_checked);
		if (mismatch_count == 0) begin
			$display("tube_bezier_control_point_generator_top verification clean");
		end else begin
			$display("tube_bezier_control_point_generator_top verification failed");
		end
		$finish;
	end

endmodule
